>>> rtl/core/multi_channel_mailbox_assert.svh
// ----------------------------------------------------------------------------
// Mailbox assertion macros
// Shorthand for clocked implication checks on clk, disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef MULTI_CHANNEL_MAILBOX_ASSERT_SVH
`define MULTI_CHANNEL_MAILBOX_ASSERT_SVH

// Same-cycle implication.
`define MCM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define MCM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/mcm_pkg.sv
// ----------------------------------------------------------------------------
// mcm_pkg
// Shared types, codes, defaults and helpers of the multi-channel mailbox.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package mcm_pkg;

  // Default sizes
  localparam int NUM_CHANNELS_DEF  = 16;
  localparam int QUEUE_DEPTH_DEF   = 8;
  localparam int PAYLOAD_BYTES_DEF = 8;

  // Operation codes
  typedef enum logic [1:0] {
    OP_CREATE = 2'd0,
    OP_CLOSE  = 2'd1,
    OP_SEND   = 2'd2,
    OP_RECV   = 2'd3
  } op_t;

  // Result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_INVALID   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DENIED    = 3'd3,
    ST_TOO_LARGE = 3'd4,
    ST_FULL      = 3'd5,
    ST_EMPTY     = 3'd6
  } status_t;

  // Sequencer states
  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_RECV
  } state_t;

  // Request payload
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  chan_sel;
    logic [15:0] agent_id;
    logic [15:0] owner_id;
    logic [15:0] permit_id;
    logic [7:0]  max_size;
    logic [7:0]  max_depth;
    logic [7:0]  msg_flags_in;
    logic [3:0]  data_len;
    logic [63:0] payload_data;
    logic [3:0]  buf_len;
  } req_t;

  // Result payload
  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] out_agent_id;
    logic [7:0]  out_flags;
    logic [3:0]  out_len;
    logic [63:0] out_data;
  } rsp_t;

  // Decision of the operation unit for the sequencer
  typedef struct packed {
    status_t status;
    logic    desc_we;
    logic    msg_we;
    logic    msg_re;
  } ctl_t;

  // Width of a queue slot index
  function automatic int q_w(input int qd);
    return (qd > 1) ? $clog2(qd) : 1;
  endfunction

  // Width of a message count (0 .. qd)
  function automatic int cnt_w(input int qd);
    return $clog2(qd + 1);
  endfunction

  // Descriptor: active, owner, permit, size limit, depth limit, head, count
  function automatic int desc_w(input int qd);
    return 41 + 2 * cnt_w(qd) + q_w(qd);
  endfunction

  // Zero every byte at and above n
  function automatic logic [63:0] keep_bytes(input logic [63:0] v, input logic [3:0] n);
    logic [63:0] res;
    res = '0;
    for (int i = 0; i < 8; i++) begin
      res[8*i +: 8] = (4'(i) < n) ? v[8*i +: 8] : 8'h00;
    end
    return res;
  endfunction

endpackage

>>> rtl/core/mcm_ram.sv
// ----------------------------------------------------------------------------
// mcm_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcm_ram #(
  parameter int WIDTH  = 8,
  parameter int ADDR_W = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [2**ADDR_W];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/core/mcm_op.sv
// ----------------------------------------------------------------------------
// mcm_op
// Checks one request against its channel descriptor and forms the updated
// descriptor, the queue slot and the message entry to store.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module mcm_op #(
  parameter int NUM_CHANNELS  = mcm_pkg::NUM_CHANNELS_DEF,
  parameter int QUEUE_DEPTH   = mcm_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BYTES = mcm_pkg::PAYLOAD_BYTES_DEF,
  localparam int Q_W    = mcm_pkg::q_w(QUEUE_DEPTH),
  localparam int CNT_W  = mcm_pkg::cnt_w(QUEUE_DEPTH),
  localparam int DESC_W = mcm_pkg::desc_w(QUEUE_DEPTH),
  localparam int DATA_W = 8 * PAYLOAD_BYTES,
  localparam int MSG_W  = 28 + DATA_W
) (
  input  mcm_pkg::req_t     req,
  input  logic [DESC_W-1:0] desc_rd,
  output logic [DESC_W-1:0] desc_wr,
  output logic [Q_W-1:0]    slot,
  output logic [MSG_W-1:0]  msg_wr,
  output mcm_pkg::ctl_t     ctl
);

  logic             active;
  logic [15:0]      owner;
  logic [15:0]      permit;
  logic [7:0]       size_lim;
  logic [CNT_W-1:0] depth_lim;
  logic [Q_W-1:0]   head;
  logic [CNT_W-1:0] count;

  logic             active_next;
  logic [15:0]      owner_next;
  logic [15:0]      permit_next;
  logic [7:0]       size_lim_next;
  logic [CNT_W-1:0] depth_lim_next;
  logic [Q_W-1:0]   head_next;
  logic [CNT_W-1:0] count_next;

  logic             chan_ok;
  logic             allowed;
  logic [CNT_W:0]   tail_sum;
  logic [CNT_W:0]   tail_wrap;
  logic [Q_W-1:0]   tail;

  assign {active, owner, permit, size_lim, depth_lim, head, count} = desc_rd;
  assign desc_wr = {active_next, owner_next, permit_next, size_lim_next,
                    depth_lim_next, head_next, count_next};

  assign chan_ok = ({3'b000, req.chan_sel} < 11'(NUM_CHANNELS));
  assign allowed = (permit == 16'h0000) || (owner == req.agent_id) ||
                   (permit == req.agent_id);

  // Tail slot: head plus count, wrapped once around the queue
  assign tail_sum  = (CNT_W+1)'(head) + (CNT_W+1)'(count);
  assign tail_wrap = (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) ?
                     tail_sum - (CNT_W+1)'(QUEUE_DEPTH) : tail_sum;
  assign tail      = tail_wrap[Q_W-1:0];

  assign slot = (req.op == mcm_pkg::OP_SEND) ? tail : head;

  // Message entry as stored: bytes past the length are dropped
  assign msg_wr = {req.agent_id, req.msg_flags_in, req.data_len,
                   DATA_W'(mcm_pkg::keep_bytes(req.payload_data, req.data_len))};

  // Decide status and descriptor update
  always_comb begin
    ctl.status     = mcm_pkg::ST_OK;
    ctl.desc_we    = 1'b0;
    ctl.msg_we     = 1'b0;
    ctl.msg_re     = 1'b0;
    active_next    = active;
    owner_next     = owner;
    permit_next    = permit;
    size_lim_next  = size_lim;
    depth_lim_next = depth_lim;
    head_next      = head;
    count_next     = count;

    if (req.op == mcm_pkg::OP_CREATE) begin
      if (!chan_ok) begin
        ctl.status = mcm_pkg::ST_INVALID;
      end else if (active) begin
        ctl.status = mcm_pkg::ST_DENIED;
      end else begin
        ctl.desc_we    = 1'b1;
        active_next    = 1'b1;
        owner_next     = req.owner_id;
        permit_next    = req.permit_id;
        size_lim_next  = req.max_size;
        depth_lim_next = ({1'b0, req.max_depth} > 9'(QUEUE_DEPTH)) ?
                         CNT_W'(QUEUE_DEPTH) : CNT_W'(req.max_depth);
        head_next      = '0;
        count_next     = '0;
      end
    end else if (!chan_ok || !active) begin
      ctl.status = mcm_pkg::ST_NOT_FOUND;
    end else begin
      case (req.op)
        mcm_pkg::OP_CLOSE: begin
          if (owner != req.agent_id) begin
            ctl.status = mcm_pkg::ST_DENIED;
          end else begin
            ctl.desc_we = 1'b1;
            active_next = 1'b0;
            head_next   = '0;
            count_next  = '0;
          end
        end
        mcm_pkg::OP_SEND: begin
          if (!allowed) begin
            ctl.status = mcm_pkg::ST_DENIED;
          end else if (({4'b0000, req.data_len} > size_lim) ||
                       (req.data_len > 4'(PAYLOAD_BYTES))) begin
            ctl.status = mcm_pkg::ST_TOO_LARGE;
          end else if (count >= depth_lim) begin
            ctl.status = mcm_pkg::ST_FULL;
          end else begin
            ctl.desc_we = 1'b1;
            ctl.msg_we  = 1'b1;
            count_next  = count + CNT_W'(1);
          end
        end
        mcm_pkg::OP_RECV: begin
          if (count == '0) begin
            ctl.status = mcm_pkg::ST_EMPTY;
          end else begin
            ctl.desc_we = 1'b1;
            ctl.msg_re  = 1'b1;
            head_next   = (head == Q_W'(QUEUE_DEPTH - 1)) ? '0 : head + Q_W'(1);
            count_next  = count - CNT_W'(1);
          end
        end
        default: begin
          ctl.status = mcm_pkg::ST_OK;
        end
      endcase
    end
  end

endmodule

>>> rtl/core/multi_channel_mailbox.sv
// ----------------------------------------------------------------------------
// multi_channel_mailbox
// Table of message channels, each a FIFO of messages in one shared store.
// Requests are handled one at a time: create, close and send pass through a
// descriptor read, then a check and write back; receive adds a further step
// for the message store read. Both follow from the registered read data of
// the descriptor and message memories. A request may be taken while the
// previous result still waits in the output register; the block then holds
// in its execute step until that result is taken. After reset a sweep over
// all NUM_CHANNELS entries clears the channel table, with req_stall high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_channel_mailbox #(
  parameter int NUM_CHANNELS  = mcm_pkg::NUM_CHANNELS_DEF,
  parameter int QUEUE_DEPTH   = mcm_pkg::QUEUE_DEPTH_DEF,
  parameter int PAYLOAD_BYTES = mcm_pkg::PAYLOAD_BYTES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_stall,
  input  mcm_pkg::req_t req,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output mcm_pkg::rsp_t rsp
);

  localparam int CH_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int Q_W    = mcm_pkg::q_w(QUEUE_DEPTH);
  localparam int DESC_W = mcm_pkg::desc_w(QUEUE_DEPTH);
  localparam int DATA_W = 8 * PAYLOAD_BYTES;
  localparam int MSG_W  = 28 + DATA_W;

  mcm_pkg::state_t   state, state_next;
  mcm_pkg::req_t     req_q;
  logic [CH_W-1:0]   clr_idx;
  logic              clr_last;
  logic              out_free;

  logic              desc_we, desc_re;
  logic [CH_W-1:0]   desc_waddr;
  logic [DESC_W-1:0] desc_wdata, desc_rd, desc_wr;

  logic              msg_we, msg_re;
  logic [Q_W-1:0]    slot;
  logic [MSG_W-1:0]  msg_wr, msg_rd;
  logic [CH_W+Q_W-1:0] msg_addr;

  mcm_pkg::ctl_t     ctl;
  logic              load_exec, load_recv;

  logic [15:0]       m_agent;
  logic [7:0]        m_flags;
  logic [3:0]        m_len;
  logic [DATA_W-1:0] m_data;
  logic [3:0]        rx_len;

  assign out_free  = !rsp_valid || !rsp_stall;
  assign clr_last  = (clr_idx == CH_W'(NUM_CHANNELS - 1));
  assign req_stall = (state != mcm_pkg::S_IDLE);
  assign msg_addr  = {CH_W'(req_q.chan_sel), slot};

  // Channel descriptor table
  mcm_ram #(
    .WIDTH  (DESC_W),
    .ADDR_W (CH_W)
  ) u_desc_ram (
    .clk   (clk),
    .we    (desc_we),
    .waddr (desc_waddr),
    .wdata (desc_wdata),
    .re    (desc_re),
    .raddr (CH_W'(req.chan_sel)),
    .rdata (desc_rd)
  );

  // Shared message store, one row of slots per channel
  mcm_ram #(
    .WIDTH  (MSG_W),
    .ADDR_W (CH_W + Q_W)
  ) u_msg_ram (
    .clk   (clk),
    .we    (msg_we),
    .waddr (msg_addr),
    .wdata (msg_wr),
    .re    (msg_re),
    .raddr (msg_addr),
    .rdata (msg_rd)
  );

  mcm_op #(
    .NUM_CHANNELS  (NUM_CHANNELS),
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PAYLOAD_BYTES (PAYLOAD_BYTES)
  ) u_op (
    .req     (req_q),
    .desc_rd (desc_rd),
    .desc_wr (desc_wr),
    .slot    (slot),
    .msg_wr  (msg_wr),
    .ctl     (ctl)
  );

  // State register and clear sweep counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= mcm_pkg::S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == mcm_pkg::S_CLEAR) begin
        clr_idx <= clr_idx + CH_W'(1);
      end
    end
  end

  // Next state and memory strobes
  always_comb begin
    state_next = state;
    desc_re    = 1'b0;
    desc_we    = 1'b0;
    desc_waddr = CH_W'(req_q.chan_sel);
    desc_wdata = desc_wr;
    msg_we     = 1'b0;
    msg_re     = 1'b0;
    load_exec  = 1'b0;
    load_recv  = 1'b0;
    case (state)
      mcm_pkg::S_CLEAR: begin
        desc_we    = 1'b1;
        desc_waddr = clr_idx;
        desc_wdata = '0;
        if (clr_last) begin
          state_next = mcm_pkg::S_IDLE;
        end
      end
      mcm_pkg::S_IDLE: begin
        desc_re = req_valid;
        if (req_valid) begin
          state_next = mcm_pkg::S_EXEC;
        end
      end
      mcm_pkg::S_EXEC: begin
        if (out_free) begin
          desc_we = ctl.desc_we;
          msg_we  = ctl.msg_we;
          msg_re  = ctl.msg_re;
          if (ctl.msg_re) begin
            state_next = mcm_pkg::S_RECV;
          end else begin
            load_exec  = 1'b1;
            state_next = mcm_pkg::S_IDLE;
          end
        end
      end
      mcm_pkg::S_RECV: begin
        load_recv  = 1'b1;
        state_next = mcm_pkg::S_IDLE;
      end
      default: begin
        state_next = mcm_pkg::S_IDLE;
      end
    endcase
  end

  // Hold the accepted request
  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_q <= req;
    end
  end

  // Clip the received message to the buffer length
  assign {m_agent, m_flags, m_len, m_data} = msg_rd;
  assign rx_len = ((req_q.buf_len != 4'd0) && (req_q.buf_len < m_len)) ?
                  req_q.buf_len : m_len;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (load_exec || load_recv) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_exec) begin
      rsp.status       <= ctl.status;
      rsp.out_agent_id <= '0;
      rsp.out_flags    <= '0;
      rsp.out_len      <= '0;
      rsp.out_data     <= '0;
    end else if (load_recv) begin
      rsp.status       <= mcm_pkg::ST_OK;
      rsp.out_agent_id <= m_agent;
      rsp.out_flags    <= m_flags;
      rsp.out_len      <= rx_len;
      rsp.out_data     <= mcm_pkg::keep_bytes(64'(m_data), rx_len);
    end
  end

  `include "multi_channel_mailbox_assert.svh"

  // A receive result never lands on a result still waiting
  `MCM_ASSERT_IMP(a_recv_out_empty, state == mcm_pkg::S_RECV, !rsp_valid, "recv overwrites result")
  // Messages are stored only by a send that passed every check
  `MCM_ASSERT_IMP(a_store_ok, msg_we, ctl.status == mcm_pkg::ST_OK && req_q.op == mcm_pkg::OP_SEND, "store write without ok send")
  // A new result comes only from the execute or receive step
  `MCM_ASSERT_IMP(a_rsp_source, $rose(rsp_valid), $past(state == mcm_pkg::S_EXEC) || $past(state == mcm_pkg::S_RECV), "result without request")
  // The clear sweep ends in idle
  `MCM_ASSERT_NXT(a_clear_done, state == mcm_pkg::S_CLEAR && clr_last, state == mcm_pkg::S_IDLE, "clear sweep overrun")

endmodule

>>> tb/multi_channel_mailbox_test.sv
// ----------------------------------------------------------------------------
// multi_channel_mailbox_test
// Drives create, close, send and receive requests into the mailbox and checks
// every result against an in-bench model of the channel table and message
// store. A short directed sequence hits each status code. A long random run
// then follows, with gaps and stalls on both sides, one long result hold-off
// and one full drain.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module multi_channel_mailbox_test;
  import mcm_pkg::*;

  localparam int NCH         = NUM_CHANNELS_DEF;
  localparam int QD          = QUEUE_DEPTH_DEF;
  localparam int PB          = PAYLOAD_BYTES_DEF;
  localparam int N_RANDOM    = 1075;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam int LONG_HOLD   = 300;
  localparam int HOLD_AT     = 250;
  localparam int DRAIN_AT    = 600;

  // Expected-result tracking for the mailbox
  class mailbox_scoreboard;
    bit          active    [NCH];
    logic [15:0] owner     [NCH];
    logic [15:0] permit    [NCH];
    logic [7:0]  size_lim  [NCH];
    int unsigned depth_lim [NCH];
    int unsigned head      [NCH];
    int unsigned count     [NCH];
    logic [15:0] msg_agent [NCH*QD];
    logic [7:0]  msg_flags [NCH*QD];
    logic [3:0]  msg_len   [NCH*QD];
    logic [63:0] msg_data  [NCH*QD];
    rsp_t        pending[$];
    int          accepted;
    int          checked;
    int          mismatches;
    int          status_seen[8];

    function logic [63:0] low_bytes(logic [63:0] v, int unsigned n);
      if (n >= 8) return v;
      return v & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    // Apply one request to the channel table and return its result
    function rsp_t apply_request(req_t r);
      rsp_t        e;
      int unsigned ch;
      int unsigned a;
      int unsigned len;
      bit          id_ok;
      bit          allowed;
      e     = '0;
      ch    = r.chan_sel;
      id_ok = ch < NCH;
      e.status = ST_OK;
      if (r.op == OP_CREATE) begin
        if (!id_ok) begin
          e.status = ST_INVALID;
        end else if (active[ch]) begin
          e.status = ST_DENIED;
        end else begin
          owner[ch]     = r.owner_id;
          permit[ch]    = r.permit_id;
          size_lim[ch]  = r.max_size;
          depth_lim[ch] = (r.max_depth > QD) ? QD : r.max_depth;
          head[ch]      = 0;
          count[ch]     = 0;
          active[ch]    = 1'b1;
        end
      end else if (!id_ok || !active[ch]) begin
        e.status = ST_NOT_FOUND;
      end else if (r.op == OP_CLOSE) begin
        if (owner[ch] != r.agent_id) begin
          e.status = ST_DENIED;
        end else begin
          head[ch]   = 0;
          count[ch]  = 0;
          active[ch] = 1'b0;
        end
      end else if (r.op == OP_SEND) begin
        allowed = permit[ch] == 16'd0 || owner[ch] == r.agent_id ||
                  permit[ch] == r.agent_id;
        if (!allowed) begin
          e.status = ST_DENIED;
        end else if (r.data_len > size_lim[ch] || r.data_len > PB) begin
          e.status = ST_TOO_LARGE;
        end else if (count[ch] >= depth_lim[ch]) begin
          e.status = ST_FULL;
        end else begin
          a = ch * QD + (head[ch] + count[ch]) % QD;
          msg_agent[a] = r.agent_id;
          msg_flags[a] = r.msg_flags_in;
          msg_len[a]   = r.data_len;
          msg_data[a]  = low_bytes(r.payload_data, r.data_len);
          count[ch]++;
        end
      end else begin
        if (count[ch] == 0) begin
          e.status = ST_EMPTY;
        end else begin
          a   = ch * QD + head[ch] % QD;
          len = msg_len[a];
          if (r.buf_len != 0 && r.buf_len < len) len = r.buf_len;
          e.out_agent_id = msg_agent[a];
          e.out_flags    = msg_flags[a];
          e.out_len      = 4'(len);
          e.out_data     = low_bytes(msg_data[a], len);
          head[ch]  = (head[ch] + 1) % QD;
          count[ch]--;
        end
      end
      return e;
    endfunction

    // Note an accepted request and queue its expected result
    function void note_request(req_t r);
      rsp_t e;
      e = apply_request(r);
      pending.push_back(e);
      status_seen[e.status]++;
      accepted++;
    endfunction

    task report_mismatch(string what, logic [63:0] got, logic [63:0] want);
      mismatches++;
      $display("[%0t] result %0d %s: got %h want %h", $realtime, checked, what, got, want);
    endtask

    // Compare one accepted result with the oldest expectation
    task check_result(rsp_t got);
      rsp_t e;
      if (pending.size() == 0) begin
        report_mismatch("result with no request waiting", got.status, 0);
        return;
      end
      e = pending.pop_front();
      if (got.status !== e.status)
        report_mismatch("status", got.status, e.status);
      if (got.out_agent_id !== e.out_agent_id)
        report_mismatch("out_agent_id", got.out_agent_id, e.out_agent_id);
      if (got.out_flags !== e.out_flags)
        report_mismatch("out_flags", got.out_flags, e.out_flags);
      if (got.out_len !== e.out_len)
        report_mismatch("out_len", got.out_len, e.out_len);
      if (got.out_data !== e.out_data)
        report_mismatch("out_data", got.out_data, e.out_data);
      checked++;
    endtask
  endclass

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_stall;
  req_t  req;
  logic  rsp_valid;
  logic  rsp_stall;
  rsp_t  rsp;

  mailbox_scoreboard sb = new();

  multi_channel_mailbox DUT (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic req_t mk(op_t op, int ch, logic [15:0] agent, logic [15:0] owner_v,
                              logic [15:0] permit_v, int msize, int mdepth,
                              logic [7:0] flags, int plen, logic [63:0] data, int blen);
    req_t r;
    r.op           = op;
    r.chan_sel     = 8'(ch);
    r.agent_id     = agent;
    r.owner_id     = owner_v;
    r.permit_id    = permit_v;
    r.max_size     = 8'(msize);
    r.max_depth    = 8'(mdepth);
    r.msg_flags_in = flags;
    r.data_len     = 4'(plen);
    r.payload_data = data;
    r.buf_len      = 4'(blen);
    return r;
  endfunction

  // Pick an agent id from a small pool so that owner and permit checks match
  function automatic logic [15:0] pool_agent();
    case ($urandom_range(5))
      0: return 16'h0001;
      1: return 16'h0002;
      2: return 16'hABCD;
      3: return 16'hFFFF;
      4: return 16'h0000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic int draw_gap(bit calm);
    int p;
    if (calm) return 0;
    p = $urandom_range(99);
    if (p < 60) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 5);
  endfunction

  // Build a mostly well-formed request, steered by the tracked channel table
  function automatic req_t random_request();
    req_t r;
    int   p;
    int   ch;
    p = $urandom_range(99);
    if ($urandom_range(99) < 8) ch = $urandom_range(255, NCH);
    else if ($urandom_range(1) == 0) ch = $urandom_range(3);
    else ch = $urandom_range(NCH - 1);
    r.chan_sel = 8'(ch);
    if (p < 42) r.op = OP_SEND;
    else if (p < 78) r.op = OP_RECV;
    else if (p < 91) r.op = OP_CREATE;
    else r.op = OP_CLOSE;
    // keep channels alive: mostly turn traffic to a closed channel into a create
    if (ch < NCH && !sb.active[ch] && r.op != OP_CREATE && $urandom_range(99) < 75)
      r.op = OP_CREATE;
    r.agent_id = pool_agent();
    if (ch < NCH && sb.active[ch]) begin
      p = $urandom_range(99);
      if (p < 55) r.agent_id = sb.owner[ch];
      else if (p < 75) r.agent_id = sb.permit[ch];
    end
    r.owner_id  = pool_agent();
    r.permit_id = ($urandom_range(99) < 40) ? 16'h0000 : pool_agent();
    p = $urandom_range(99);
    if (p < 60) r.max_size = 8'($urandom_range(255, 8));
    else if (p < 85) r.max_size = 8'($urandom_range(7, 1));
    else r.max_size = 8'd0;
    p = $urandom_range(99);
    if (p < 65) r.max_depth = 8'($urandom_range(QD, 1));
    else if (p < 92) r.max_depth = 8'($urandom_range(255, QD + 1));
    else r.max_depth = 8'd0;
    r.msg_flags_in = 8'($urandom);
    r.data_len     = ($urandom_range(9) == 0) ? 4'($urandom_range(15, 9))
                                              : 4'($urandom_range(8));
    r.payload_data = {$urandom, $urandom};
    p = $urandom_range(99);
    if (p < 50) r.buf_len = 4'd0;
    else if (p < 90) r.buf_len = 4'($urandom_range(8, 1));
    else r.buf_len = 4'($urandom_range(15, 9));
    return r;
  endfunction

  // Offer one request, hold it until accepted, then idle for the given gap
  task automatic issue(input req_t r, input int gap);
    req       <= r;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall !== 1'b0);
    sb.note_request(r);
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Request side
  initial begin : request_side
    bit calm;
    rst       <= 1'b1;
    req_valid <= 1'b0;
    req       <= '0;
    calm = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // bad ids, missing channels, extremes of every field
    issue(mk(OP_CREATE, 255, 16'hFFFF, 16'hFFFF, 16'hFFFF, 255, 255, 8'hFF, 15,
             64'hFFFF_FFFF_FFFF_FFFF, 15), draw_gap(0));
    issue(mk(OP_CREATE, NCH, 16'h0, 16'h1, 16'h0, 8, 8, 8'h0, 0, 64'h0, 0), draw_gap(0));
    issue(mk(OP_SEND, 3, 16'h1, 16'h0, 16'h0, 0, 0, 8'h5A, 2, 64'h1234, 0), draw_gap(0));
    issue(mk(OP_RECV, 255, 16'h1, 16'h0, 16'h0, 0, 0, 8'h0, 0, 64'h0, 4), draw_gap(0));
    issue(mk(OP_CLOSE, 3, 16'h1, 16'h0, 16'h0, 0, 0, 8'h0, 0, 64'h0, 0), draw_gap(0));
    // public channel, depth saturated to the queue depth
    issue(mk(OP_CREATE, 0, 16'h0, 16'h0001, 16'h0, 8, 255, 8'h0, 0, 64'h0, 0), draw_gap(0));
    issue(mk(OP_CREATE, 0, 16'h0, 16'h0002, 16'h0, 8, 4, 8'h0, 0, 64'h0, 0), draw_gap(0));
    issue(mk(OP_RECV, 0, 16'h0001, 16'h0, 16'h0, 0, 0, 8'h0, 0, 64'h0, 0), draw_gap(0));
    issue(mk(OP_SEND, 0, 16'h7777, 16'h0, 16'h0, 0, 0, 8'hFF, 8,
             64'hFFFF_FFFF_FFFF_FFFF, 0), draw_gap(0));
    issue(mk(OP_SEND, 0, 16'h0000, 16'h0, 16'h0, 0, 0, 8'h00, 0,
             64'hFFFF_FFFF_FFFF_FFFF, 0), draw_gap(0));
    issue(mk(OP_SEND, 0, 16'h0001, 16'h0, 16'h0, 0, 0, 8'h11, 9, 64'h1, 0), draw_gap(0));
    // restricted channel with zero depth
    issue(mk(OP_CREATE, NCH - 1, 16'h0, 16'hFFFF, 16'h1234, 3, 0, 8'h0, 0, 64'h0, 0),
          draw_gap(0));
    issue(mk(OP_SEND, NCH - 1, 16'h4321, 16'h0, 16'h0, 0, 0, 8'h0, 1, 64'h1, 0), draw_gap(0));
    issue(mk(OP_SEND, NCH - 1, 16'h1234, 16'h0, 16'h0, 0, 0, 8'h0, 4, 64'h1, 0), draw_gap(0));
    issue(mk(OP_SEND, NCH - 1, 16'hFFFF, 16'h0, 16'h0, 0, 0, 8'h0, 3, 64'h1, 0), draw_gap(0));
    issue(mk(OP_CLOSE, NCH - 1, 16'h1234, 16'h0, 16'h0, 0, 0, 8'h0, 0, 64'h0, 0), draw_gap(0));
    issue(mk(OP_CLOSE, NCH - 1, 16'hFFFF, 16'h0, 16'h0, 0, 0, 8'h0, 0, 64'h0, 0), draw_gap(0));
    // clipped receive, then a zero-length message
    issue(mk(OP_RECV, 0, 16'h0001, 16'h0, 16'h0, 0, 0, 8'h0, 0, 64'h0, 3), draw_gap(0));
    issue(mk(OP_RECV, 0, 16'h0001, 16'h0, 16'h0, 0, 0, 8'h0, 0, 64'h0, 0), draw_gap(0));
    // fill channel 0 to its depth, then one more
    for (int k = 0; k < QD + 1; k++)
      issue(mk(OP_SEND, 0, 16'h0002, 16'h0, 16'h0, 0, 0, 8'($urandom), k % PB + 1,
               {$urandom, $urandom}, 0), draw_gap(0));
    issue(mk(OP_RECV, 0, 16'h0001, 16'h0, 16'h0, 0, 0, 8'h0, 0, 64'h0, 15), draw_gap(0));

    // random traffic, with calm stretches and one full drain
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 100 == 0) calm = ($urandom_range(3) == 0);
      if (i == DRAIN_AT) begin
        req_valid <= 1'b0;
        do @(posedge clk); while (sb.pending.size() != 0);
      end
      issue(random_request(), draw_gap(calm));
    end
    req_valid <= 1'b0;

    // wait out the results, then a short tail for strays
    do @(posedge clk); while (sb.pending.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d requests, %0d results checked, %0d mismatches",
             sb.accepted, sb.checked, sb.mismatches);
    $display("ok %0d, invalid %0d, not found %0d, denied %0d, too large %0d, full %0d, empty %0d",
             sb.status_seen[ST_OK], sb.status_seen[ST_INVALID], sb.status_seen[ST_NOT_FOUND],
             sb.status_seen[ST_DENIED], sb.status_seen[ST_TOO_LARGE], sb.status_seen[ST_FULL],
             sb.status_seen[ST_EMPTY]);
    if (sb.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Result side: check accepted results, stall at random, one long hold-off
  initial begin : result_side
    int stall_left;
    int window;
    bit calm;
    bit held;
    rsp_stall <= 1'b0;
    stall_left = 0;
    window     = 0;
    calm       = 1'b0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && rsp_valid === 1'b1 && rsp_stall === 1'b0) sb.check_result(rsp);
      window++;
      if (window == 64) begin
        window = 0;
        calm   = ($urandom_range(3) == 0);
      end
      if (!held && sb.checked >= HOLD_AT) begin
        held       = 1'b1;
        stall_left = LONG_HOLD;
      end else if (stall_left == 0 && !calm && $urandom_range(99) < 25) begin
        stall_left = ($urandom_range(9) == 0) ? $urandom_range(30, 8) : $urandom_range(3, 1);
      end
      rsp_stall <= (stall_left != 0);
      if (stall_left != 0) stall_left--;
    end
  end

  // Stop a hung run
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
        $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending.size());
        $display("status: fail");
        $finish;
      end
    end
  end

endmodule
